FILE: sv/glr_pkg.sv
// glr_pkg: shared types and constants for the grid line rasteriser.
// No dependencies; imported by every module of the block.
package glr_pkg;

  localparam int CELL_W          = 16;  // width of cell_x / cell_y
  localparam int COORD_IN_W      = 16;  // width of the endpoint ports
  localparam int GW_W            = 16;  // width of the grid_width register
  localparam int DEF_MAX_POINTS  = 64;
  localparam int DEF_COORD_BITS  = 16;

  localparam logic [GW_W-1:0] GRID_WIDTH_RST = 16'd32;

  // register index, taken from paddr[2]
  localparam logic REG_GRID_WIDTH = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORDER,
    ST_CHECK,
    ST_DIV_MAJ,
    ST_DIV_MIN,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic capture;     // latch the endpoints of an accepted request
    logic order;       // choose axes, order endpoints, load spans
    logic div_start;   // start a division by the grid width
    logic div_minor;   // 1: divide the minor start, 0: the major start
    logic take_major;  // quotient -> major cell
    logic take_minor;  // quotient -> minor cell
    logic emit;        // load the next point into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic span_zero;   // segment has no length along the major axis
    logic div_done;    // divider quotient ready this cycle
    logic out_free;    // output register can take a point
    logic last;        // point about to be emitted is the final one
  } dp_status_t;

endpackage

FILE: sv/glr_divider.sv
// glr_divider: restoring divider, one quotient bit per cycle.
// Divides a coordinate by the grid width. Depends on glr_pkg.
module glr_divider #(
  parameter int NUM_W = glr_pkg::DEF_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUM_W-1:0]        numer,
  input  logic [glr_pkg::GW_W-1:0] denom,
  output logic                    done,
  output logic [NUM_W-1:0]        quot
);
  import glr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [GW_W-1:0]  rem_r;
  logic [GW_W-1:0]  den_r;
  logic [NUM_W-1:0] quot_r;

  logic [GW_W:0]    rem_sh;
  logic [GW_W:0]    rem_diff;
  logic             ge;
  logic [GW_W-1:0]  rem_nxt;
  logic [NUM_W-1:0] quot_nxt;

  always_comb begin
    rem_sh   = {rem_r, quot_r[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_nxt  = ge ? rem_diff[GW_W-1:0] : rem_sh[GW_W-1:0];
    quot_nxt = {quot_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      den_r  <= denom;
      quot_r <= numer;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: sv/glr_datapath.sv
// glr_datapath: endpoint ordering, Bresenham walk state and output register.
// Depends on glr_pkg and glr_divider; driven by glr_controller commands.
module glr_datapath #(
  parameter int MAX_POINTS = glr_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = glr_pkg::DEF_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  glr_pkg::dp_cmd_t               cmd,
  output glr_pkg::dp_status_t            status,
  input  logic [glr_pkg::GW_W-1:0]       gw,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_start_x,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_start_y,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_end_x,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_end_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [glr_pkg::CELL_W-1:0]     out_cell_x,
  output logic [glr_pkg::CELL_W-1:0]     out_cell_y,
  output logic                           out_last_point,
  output logic                           out_truncated
);
  import glr_pkg::*;

  // coordinates used: low COORD_BITS bits of the 16-bit ports
  localparam int CW    = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
  localparam int POS_W = GW_W + 1;
  localparam int PW    = $clog2(MAX_POINTS + 1);
  localparam int ERR_W = CW + 2;

  logic [CW-1:0] sx_r, sy_r, ex_r, ey_r;

  logic [POS_W-1:0]        major_pos_r;
  logic [CW-1:0]           major_end_r;
  logic [CW-1:0]           minor_start_r;
  logic [CELL_W-1:0]       minor_cell_r;
  logic [CELL_W-1:0]       major_cell_r;
  logic signed [ERR_W-1:0] error_acc_r;
  logic [CW-1:0]           span_major_r;
  logic [CW-1:0]           span_minor_r;
  logic                    axis_swapped_r;
  logic                    minor_down_r;
  logic [PW-1:0]           points_sent_r;

  logic              out_valid_r;
  logic [CELL_W-1:0] out_cell_x_r;
  logic [CELL_W-1:0] out_cell_y_r;
  logic              out_last_r;
  logic              out_trunc_r;
  logic              out_valid_nxt;

  // ordering
  logic [CW-1:0] dx, dy, p1a, p1b, p2a, p2b, a1, b1, a2, b2, smaj, smin;
  logic          steep, flip;

  always_comb begin
    dx    = (sx_r > ex_r) ? (sx_r - ex_r) : (ex_r - sx_r);
    dy    = (sy_r > ey_r) ? (sy_r - ey_r) : (ey_r - sy_r);
    steep = (dy > dx);
    p1a   = steep ? sy_r : sx_r;
    p1b   = steep ? sx_r : sy_r;
    p2a   = steep ? ey_r : ex_r;
    p2b   = steep ? ex_r : ey_r;
    flip  = (p1a > p2a);
    a1    = flip ? p2a : p1a;
    b1    = flip ? p2b : p1b;
    a2    = flip ? p1a : p2a;
    b2    = flip ? p1b : p2b;
    smaj  = a2 - a1;
    smin  = (b1 > b2) ? (b1 - b2) : (b2 - b1);
  end

  // divider, shared by both start cells
  logic [CW-1:0] div_numer;
  logic [CW-1:0] div_quot;
  logic          div_done;

  assign div_numer = cmd.div_minor ? minor_start_r : major_pos_r[CW-1:0];

  glr_divider #(
    .NUM_W (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .numer (div_numer),
    .denom (gw),
    .done  (div_done),
    .quot  (div_quot)
  );

  // walk step
  logic [POS_W-1:0]        major_pos_nxt;
  logic                    reach_end;
  logic                    at_cap;
  logic                    last_pt;
  logic signed [ERR_W-1:0] err_add;
  logic                    minor_step;
  logic signed [ERR_W-1:0] error_acc_nxt;
  logic [CELL_W-1:0]       minor_cell_nxt;

  always_comb begin
    major_pos_nxt = major_pos_r + POS_W'(gw);
    reach_end     = (major_pos_nxt >= POS_W'(major_end_r));
    at_cap        = (points_sent_r == PW'(MAX_POINTS - 1));
    last_pt       = reach_end || at_cap;
    err_add       = error_acc_r + $signed({2'b00, span_minor_r});
    minor_step    = ($signed({err_add, 1'b0}) >= $signed({3'b000, span_major_r}));
    error_acc_nxt = minor_step ? (err_add - $signed({2'b00, span_major_r})) : err_add;
    if (!minor_step) begin
      minor_cell_nxt = minor_cell_r;
    end else if (minor_down_r) begin
      // saturate at row zero
      minor_cell_nxt = (minor_cell_r != '0) ? (minor_cell_r - 1'b1) : minor_cell_r;
    end else begin
      minor_cell_nxt = minor_cell_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx_r <= in_start_x[CW-1:0];
      sy_r <= in_start_y[CW-1:0];
      ex_r <= in_end_x[CW-1:0];
      ey_r <= in_end_y[CW-1:0];
    end
    if (cmd.order) begin
      axis_swapped_r <= steep;
      major_pos_r    <= POS_W'(a1);
      major_end_r    <= a2;
      minor_start_r  <= b1;
      span_major_r   <= smaj;
      span_minor_r   <= smin;
      minor_down_r   <= !(b1 < b2);
      error_acc_r    <= '0;
      points_sent_r  <= '0;
    end
    if (cmd.take_major) begin
      major_cell_r <= CELL_W'(div_quot);
    end
    if (cmd.take_minor) begin
      minor_cell_r <= CELL_W'(div_quot);
    end
    if (cmd.emit) begin
      out_cell_x_r  <= axis_swapped_r ? minor_cell_r : major_cell_r;
      out_cell_y_r  <= axis_swapped_r ? major_cell_r : minor_cell_r;
      out_last_r    <= last_pt;
      out_trunc_r   <= last_pt && !reach_end;
      minor_cell_r  <= minor_cell_nxt;
      error_acc_r   <= error_acc_nxt;
      major_pos_r   <= major_pos_nxt;
      major_cell_r  <= major_cell_r + 1'b1;
      points_sent_r <= points_sent_r + 1'b1;
    end
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.span_zero = (span_major_r == '0);
  assign status.div_done  = div_done;
  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.last      = last_pt;

  assign out_valid      = out_valid_r;
  assign out_cell_x     = out_cell_x_r;
  assign out_cell_y     = out_cell_y_r;
  assign out_last_point = out_last_r;
  assign out_truncated  = out_trunc_r;

  // a point is only ever emitted for a segment of non-zero length
  a_emit_span: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> span_major_r != '0)
    else $error("point emitted for zero-length segment");

  // error term stays below half a major span between points
  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> $signed({error_acc_r, 1'b0}) < $signed({3'b000, span_major_r}))
    else $error("error accumulator out of range");

  // point count never passes the cap
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> points_sent_r <= PW'(MAX_POINTS - 1))
    else $error("point count beyond limit");

  // a downward walk never moves the minor cell up
  a_down: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && minor_down_r) |=> minor_cell_r <= $past(minor_cell_r))
    else $error("minor cell rose on a downward walk");

endmodule

FILE: sv/glr_controller.sv
// glr_controller: sequencer for one segment at a time.
// Depends on glr_pkg; drives glr_datapath through dp_cmd_t.
module glr_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  glr_pkg::dp_status_t status,
  output glr_pkg::dp_cmd_t    cmd
);
  import glr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_ORDER;
      end
      ST_ORDER: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = status.span_zero ? ST_IDLE : ST_DIV_MAJ;
      end
      ST_DIV_MAJ: begin
        if (status.div_done) state_nxt = ST_DIV_MIN;
      end
      ST_DIV_MIN: begin
        if (status.div_done) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (status.out_free && status.last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_ORDER: begin
        cmd.order = 1'b1;
      end
      ST_CHECK: begin
        cmd.div_start = !status.span_zero;
      end
      ST_DIV_MAJ: begin
        cmd.take_major = status.div_done;
        cmd.div_start  = status.div_done;
        cmd.div_minor  = 1'b1;
      end
      ST_DIV_MIN: begin
        cmd.div_minor  = 1'b1;
        cmd.take_minor = status.div_done;
      end
      ST_WALK: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/grid_line_rasterizer.sv
// grid_line_rasterizer: top level, APB-style register and block wiring.
// Depends on glr_pkg, glr_controller, glr_datapath (and glr_divider below it).
//
// Takes one segment request (two pixel endpoints) at a time and emits the
// grid cells along it, one result request per point, as an integer
// Bresenham walk: x is the major axis unless the y span is strictly larger,
// the walk runs up the major axis from the lower endpoint in steps of
// grid_width pixels, and the far endpoint is never emitted. At most
// MAX_POINTS points come out; when the walk is cut there, the last point
// carries truncated. A zero-length segment gives no results. A grid_width of
// zero acts as one. The bit-serial divider works out the two start cells
// (lower endpoint divided by grid_width) one after the other; the walk
// then emits one point per cycle while the output is not stalled. The last
// point can sit in the output register while the next segment is accepted.
// grid_width may be rewritten only while the block is idle.
module grid_line_rasterizer #(
  parameter int MAX_POINTS = glr_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = glr_pkg::DEF_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // segment requests
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_start_x,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_start_y,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_end_x,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_end_y,
  // point results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [glr_pkg::CELL_W-1:0]     out_cell_x,
  output logic [glr_pkg::CELL_W-1:0]     out_cell_y,
  output logic                           out_last_point,
  output logic                           out_truncated,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import glr_pkg::*;

  // grid_width register, byte address 0; paddr[2] picks the register
  logic [GW_W-1:0] grid_width_r;
  logic [GW_W-1:0] grid_width_nxt;
  logic            reg_wr;
  logic [GW_W-1:0] gw_eff;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_comb begin
    grid_width_nxt = grid_width_r;
    if (reg_wr && (paddr[2] == REG_GRID_WIDTH)) begin
      grid_width_nxt = pwdata[GW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= GRID_WIDTH_RST;
    end else begin
      grid_width_r <= grid_width_nxt;
    end
  end

  // reads of addresses past the register list return zero
  assign prdata = (paddr[2] == REG_GRID_WIDTH) ? {16'h0000, grid_width_r} : 32'h0;

  // zero width would stall the walk: treat as one pixel per cell
  assign gw_eff = (grid_width_r == '0) ? GW_W'(1) : grid_width_r;

  dp_cmd_t    cmd;
  dp_status_t status;

  glr_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  glr_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .gw             (gw_eff),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_x     (out_cell_x),
    .out_cell_y     (out_cell_y),
    .out_last_point (out_last_point),
    .out_truncated  (out_truncated)
  );

endmodule

FILE: tb/sv/glr_cell_checker.sv
// glr_cell_checker: follows the segment, point and register traffic of the
// grid line rasteriser, predicts every point and compares. Depends on glr_pkg.
module glr_cell_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_start_x,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_start_y,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_end_x,
  input  logic [glr_pkg::COORD_IN_W-1:0] in_end_y,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [glr_pkg::CELL_W-1:0]     out_cell_x,
  input  logic [glr_pkg::CELL_W-1:0]     out_cell_y,
  input  logic                           out_last_point,
  input  logic                           out_truncated,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  output int                             errors,
  output int                             pending,
  output int                             segments_taken,
  output int                             points_checked,
  output int                             cut_runs
);
  import glr_pkg::*;

  localparam int MAX_CELLS = DEF_MAX_POINTS;

  typedef struct packed {
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              last_point;
    logic              truncated;
  } grid_point_t;

  grid_point_t     cells_due[$];
  logic [GW_W-1:0] grid_width_copy;
  int              mismatches;
  int              n_segments;
  int              n_points;
  int              n_cut;

  function automatic logic [15:0] span_of(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Integer Bresenham walk; queues the cells this segment should produce.
  function automatic void plot_segment(input logic [15:0] sx, input logic [15:0] sy,
                                       input logic [15:0] ex, input logic [15:0] ey,
                                       input logic [GW_W-1:0] gw_reg);
    logic [15:0] gw, a1, b1, a2, b2, tmp, maj_cell, min_cell;
    int          span_maj, span_min, err, total, n;
    bit          steep, down, cut;
    grid_point_t p;
    gw = (gw_reg == '0) ? 16'd1 : gw_reg;
    steep = span_of(sy, ey) > span_of(sx, ex);
    if (steep) begin
      a1 = sy; b1 = sx; a2 = ey; b2 = ex;
    end else begin
      a1 = sx; b1 = sy; a2 = ex; b2 = ey;
    end
    if (a1 > a2) begin
      tmp = a1; a1 = a2; a2 = tmp;
      tmp = b1; b1 = b2; b2 = tmp;
    end
    span_maj = int'(a2) - int'(a1);
    span_min = int'(span_of(b1, b2));
    down     = !(b1 < b2);
    maj_cell = a1 / gw;
    min_cell = b1 / gw;
    err      = 0;
    total    = (span_maj + int'(gw) - 1) / int'(gw);
    cut      = total > MAX_CELLS;
    n        = cut ? MAX_CELLS : total;
    for (int k = 0; k < n; k++) begin
      p.cell_x     = steep ? min_cell : maj_cell;
      p.cell_y     = steep ? maj_cell : min_cell;
      p.last_point = (k + 1 == n);
      p.truncated  = (k + 1 == n) && cut;
      cells_due.push_back(p);
      err += span_min;
      if (2 * err >= span_maj) begin
        if (down) begin
          if (min_cell != 16'd0) min_cell--;   // saturate at row/column zero
        end else begin
          min_cell++;
        end
        err -= span_maj;
      end
      maj_cell++;
    end
  endfunction

  task automatic match_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    grid_point_t want;
    if (!rst_n) begin
      cells_due.delete();
      grid_width_copy = GRID_WIDTH_RST;
      mismatches = 0;
      n_segments = 0;
      n_points   = 0;
      n_cut      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cells_due.size() == 0) begin
          $error("point (%0d,%0d) with no point due", out_cell_x, out_cell_y);
          mismatches++;
        end else begin
          want = cells_due.pop_front();
          match_field("cell_x", want.cell_x, out_cell_x);
          match_field("cell_y", want.cell_y, out_cell_y);
          match_field("last_point", want.last_point, out_last_point);
          match_field("truncated", want.truncated, out_truncated);
          n_points++;
          if (out_truncated) n_cut++;
        end
      end
      if (in_valid && !in_stall) begin
        plot_segment(in_start_x, in_start_y, in_end_x, in_end_y, grid_width_copy);
        n_segments++;
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_GRID_WIDTH)
        grid_width_copy = pwdata[GW_W-1:0];
    end
    errors         <= mismatches;
    pending        <= cells_due.size();
    segments_taken <= n_segments;
    points_checked <= n_points;
    cut_runs       <= n_cut;
  end

endmodule

FILE: tb/sv/grid_line_rasterizer_test.sv
// grid_line_rasterizer_test: top of the rasteriser bench; clock, reset,
// segment and register stimulus, output stalls and the verdict.
// Depends on glr_pkg, grid_line_rasterizer and glr_cell_checker.
module grid_line_rasterizer_test;
  import glr_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int SETTLE_CYCLES = 120;     // longer than a capped run
  localparam int HOLD_CYCLES   = 400;     // long output hold-off
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 30;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // segment request side
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [COORD_IN_W-1:0] in_start_x = '0;
  logic [COORD_IN_W-1:0] in_start_y = '0;
  logic [COORD_IN_W-1:0] in_end_x   = '0;
  logic [COORD_IN_W-1:0] in_end_y   = '0;

  // point request side
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CELL_W-1:0] out_cell_x;
  logic [CELL_W-1:0] out_cell_y;
  logic              out_last_point;
  logic              out_truncated;

  // register port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // bench control; all but cur_gw written with NBAs so the receiver sees them cleanly
  logic calm    = 1'b0;   // no idling on either side
  logic hold_go = 1'b0;   // ask the receiver for its long hold-off
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cur_gw    = -1;   // last grid width written, -1 before the first

  int errors, pending, segments_taken, points_checked, cut_runs;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  grid_line_rasterizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cell_x(out_cell_x), .out_cell_y(out_cell_y),
    .out_last_point(out_last_point), .out_truncated(out_truncated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  glr_cell_checker cell_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cell_x(out_cell_x), .out_cell_y(out_cell_y),
    .out_last_point(out_last_point), .out_truncated(out_truncated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .segments_taken(segments_taken),
    .points_checked(points_checked), .cut_runs(cut_runs)
  );

  // Receiver: random stalls, one long hold-off on request, none when calm.
  // The hold-off is counted here so the sender keeps pushing meanwhile and
  // the block backs up into in_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  // Present one segment request and hold it until the block takes it.
  // in_valid is left high; the caller decides whether a gap follows.
  task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
    in_valid   <= 1'b1;
    in_start_x <= sx[COORD_IN_W-1:0];
    in_start_y <= sy[COORD_IN_W-1:0];
    in_end_x   <= ex[COORD_IN_W-1:0];
    in_end_y   <= ey[COORD_IN_W-1:0];
    do @(posedge clk); while (in_stall);
  endtask

  // Occasional idle cycles between requests, skipped during the calm stretch.
  task automatic pause_sender();
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Let everything drain: all points out, then enough cycles for a walk
  // that produces nothing (zero length) to finish as well.
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access cycle; the write lands when pready is seen high.
  task automatic write_grid_width(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_GRID_WIDTH, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_gw  = value;
  endtask

  // Directed segment under a given grid width; the register only changes
  // once the block has gone idle.
  task automatic directed(input int gw, input int sx, input int sy, input int ex, input int ey);
    if (gw != cur_gw) begin
      settle();
      write_grid_width(gw);
    end
    send_segment(sx, sy, ex, ey);
    pause_sender();
  endtask

  // Step d pixels away from s in a random direction, staying on the grid.
  function automatic int offset_coord(input int s, input int d);
    int e;
    if ($urandom_range(0, 1)) d = -d;
    e = s + d;
    if (e > 65535 || e < 0) e = s - d;
    if (e > 65535) e = 65535;
    if (e < 0) e = 0;
    return e;
  endfunction

  initial begin
    int gw, g_eff, kind, sx, sy, ex, ey, dmaj, dmin, lim;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, default grid width first ---
    directed(32, 0, 0, 0, 0);                 // zero length
    directed(32, 65535, 65535, 65535, 65535); // zero length at the far corner
    directed(32, 0, 0, 65535, 65535);         // equal spans, cut at the limit
    directed(32, 65535, 0, 0, 65535);         // reversed, minor walking down
    directed(32, 0, 31, 320, 0);              // minor below row zero clamps
    directed(32, 5, 0, 0, 400);               // steep, minor below zero
    directed(32, 10, 10, 100, 1000);          // steep, minor up
    directed(32, 100, 500, 1000, 500);        // equal minor coordinates
    directed(32, 700, 0, 700, 1500);          // vertical
    directed(32, 0, 0, 5, 3);                 // shorter than one cell
    directed(32, 0, 0, 2048, 100);            // exactly the point limit
    directed(32, 0, 0, 2049, 100);            // one over, cut
    directed(32, 65535, 65535, 65504, 0);     // steep, reversed
    directed(1, 0, 0, 10, 3);
    directed(1, 100, 100, 164, 100);          // exactly the limit at width 1
    directed(1, 100, 100, 165, 37);           // cut at width 1
    directed(1, 65535, 0, 65471, 64);         // equal spans near the edge
    directed(0, 3, 9, 20, 1);                 // width zero acts as one
    directed(0, 0, 65535, 65535, 0);
    directed(65535, 0, 0, 65535, 65535);      // widest cell, one point
    directed(65535, 65535, 65535, 1, 2);
    directed(65535, 0, 0, 65534, 3);
    directed(7, 50, 60, 10, 200);

    // --- random part, one grid width per phase ---
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: gw = 1;
        1: gw = 65535;
        2: gw = 0;
        3: gw = 5;
        4: gw = $urandom_range(2, 64);
        5: gw = 32;
        6: gw = $urandom_range(1, 65535);
        default: gw = 3;
      endcase
      settle();
      write_grid_width(gw);
      g_eff = (gw == 0) ? 1 : gw;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == 4) hold_go <= 1'b1;
        if (ph == 5 && i == 8) calm <= 1'b1;
        if (ph == 5 && i == 28) calm <= 1'b0;
        kind = $urandom_range(0, 99);
        sx = $urandom_range(0, 65535);
        sy = $urandom_range(0, 65535);
        if (kind < 8) begin
          ex = $urandom_range(0, 65535);       // noise: anything goes
          ey = $urandom_range(0, 65535);
        end else if (kind < 12) begin
          ex = sx;                             // zero length
          ey = sy;
        end else begin
          // mostly short walks, a few cells to a little past the limit
          lim = g_eff * $urandom_range(0, 70 - 50 * (kind % 2));
          if (lim > 65535) lim = 65535;
          dmaj = $urandom_range(0, lim);
          dmin = (kind < 17) ? dmaj : $urandom_range(0, dmaj);
          if ($urandom_range(0, 1)) begin
            ex = offset_coord(sx, dmin);
            ey = offset_coord(sy, dmaj);
          end else begin
            ex = offset_coord(sx, dmaj);
            ey = offset_coord(sy, dmin);
          end
        end
        send_segment(sx, sy, ex, ey);
        pause_sender();
      end
    end

    settle();
    $display("Covered %0d segments, %0d points checked, %0d runs cut at the point limit.",
             segments_taken, points_checked, cut_runs);
    $display("Grid widths 32, 1, 0, 65535, 7, 5, 3 and random ones; one long output hold-off.");
    if (errors == 0) begin
      $display("PASS grid_line_rasterizer");
    end else begin
      $display("FAIL grid_line_rasterizer");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("FAIL grid_line_rasterizer");
    $finish;
  end

endmodule
